FILE: rtl/pidrfs_pkg.sv
// shared types, constants and a saturating add helper function for the pid controller
package pidrfs_pkg;

  localparam int FRAC_BITS_DEF      = 8;
  localparam int INTEGRAL_WIDTH_DEF = 40;

  localparam int MV_W        = 23;
  localparam int ERR_W       = 24;
  localparam int DRV_W       = 16;
  localparam int GAIN_W      = 15;
  localparam int SUM_W       = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 4'd0,
    REG_INTEG_GAIN  = 4'd1,
    REG_DERIV_GAIN  = 4'd2,
    REG_SETPOINT    = 4'd3,
    REG_RAMP_RATE   = 4'd4,
    REG_SLEW_LIMIT  = 4'd5,
    REG_OUT_LIMITS  = 4'd6,
    REG_FF_GAINS    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [MV_W-1:0]  target;
  } drive_req_t;

  typedef struct packed {
    logic        [GAIN_W-1:0] slew;
    logic signed [DRV_W-1:0]  omin;
    logic signed [DRV_W-1:0]  omax;
  } drive_lim_t;

  function automatic logic signed [SUM_W-1:0] sat_add64(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add64 = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add64 = s[SUM_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/pid_with_ramp_feedforward_slew.sv
// pid controller with target ramp, feedforward terms and slew limited output
// a request accepted at the input passes stage registers 0 to 8 and the result register before out_tvalid
// throughput: one request per cycle while the output is not stalled; nine pipeline stages lead to the result register
// each stage holds its request on its own when the next is full, so bubbles close up
// reset: synchronous active low rst_n clears configuration and valid registers, ramp, integral and last drive
// configuration writes are taken in every cycle
module pid_with_ramp_feedforward_slew #(
  parameter int FRAC_BITS      = pidrfs_pkg::FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pidrfs_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pidrfs_pkg::IN_TDATA_W-1:0]    in_tdata,   // measured_value, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pidrfs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // drive_value, step_target, zero pad
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidrfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidrfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int IH    = IW / 2;
  localparam int IHW   = IW - IH;
  localparam int PW    = IW + 17;
  localparam int XW    = (PW > 65) ? PW : 65;
  localparam int NSTG  = 9;
  localparam int MW    = pidrfs_pkg::MV_W;
  localparam int EW    = pidrfs_pkg::ERR_W;
  localparam int GW    = pidrfs_pkg::GAIN_W;
  localparam int SW    = pidrfs_pkg::SUM_W;

  localparam logic signed [IW-1:0] ES_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] ES_MIN = {1'b1, {(IW-1){1'b0}}};

  // configuration registers
  logic        [GW-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, ramp_rate_r, slew_limit_r;
  logic signed [MW-1:0] setpoint_r;
  logic signed [15:0]   omin_r, omax_r, ff_acc_r;
  logic        [15:0]   ff_vel_r, ff_fri_r, ff_bias_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      setpoint_r   <= '0;
      ramp_rate_r  <= '0;
      slew_limit_r <= '0;
      omin_r       <= '0;
      omax_r       <= '0;
      ff_acc_r     <= '0;
      ff_vel_r     <= '0;
      ff_fri_r     <= '0;
      ff_bias_r    <= '0;
    end else if (cfg_valid) begin
      unique case (pidrfs_pkg::cfg_reg_t'(cfg_index))
        pidrfs_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_data[GW-1:0];
        pidrfs_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_data[GW-1:0];
        pidrfs_pkg::REG_DERIV_GAIN: deriv_gain_r <= cfg_data[GW-1:0];
        pidrfs_pkg::REG_SETPOINT:   setpoint_r   <= cfg_data[MW-1:0];
        pidrfs_pkg::REG_RAMP_RATE:  ramp_rate_r  <= cfg_data[GW-1:0];
        pidrfs_pkg::REG_SLEW_LIMIT: slew_limit_r <= cfg_data[GW-1:0];
        pidrfs_pkg::REG_OUT_LIMITS: begin
          omin_r <= cfg_data[15:0];
          omax_r <= cfg_data[31:16];
        end
        pidrfs_pkg::REG_FF_GAINS: begin
          ff_acc_r  <= cfg_data[15:0];
          ff_vel_r  <= cfg_data[31:16];
          ff_fri_r  <= cfg_data[47:32];
          ff_bias_r <= cfg_data[63:48];
        end
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] ld;
  logic            drv_ready;

  always_comb begin
    rdy[NSTG] = drv_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && v_r[k-1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: input register
  logic signed [MW-1:0] pv0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      pv0_r <= in_tdata[MW-1:0];
    end
  end

  // stage 1: ramp, error, derivative, integral (loop state)
  logic signed [MW-1:0] ramp_target_r;
  logic signed [IW-1:0] error_sum_r;
  logic signed [EW-1:0] previous_error_r;
  logic signed [EW:0]   deriv1_r;
  logic signed [EW-1:0] accel1_r;
  logic signed [MW-1:0] tgt1_r;
  logic                 fri1_r;

  logic signed [MW+1:0] t_ext, sp_ext, up, dn;
  logic signed [MW-1:0] ramp_target_nxt;
  logic signed [EW-1:0] err, accel;
  logic signed [EW:0]   deriv;
  logic signed [IW:0]   es_sum;
  logic signed [IW-1:0] error_sum_nxt;
  logic                 fri;

  always_comb begin
    t_ext  = (MW+2)'(ramp_target_r);
    sp_ext = (MW+2)'(setpoint_r);
    up     = t_ext + $signed((MW+2)'(ramp_rate_r));
    dn     = t_ext - $signed((MW+2)'(ramp_rate_r));
    if (ramp_rate_r != '0 && ramp_target_r != setpoint_r) begin
      if (ramp_target_r < setpoint_r) begin
        ramp_target_nxt = (up > sp_ext) ? setpoint_r : up[MW-1:0];
      end else begin
        ramp_target_nxt = (dn < sp_ext) ? setpoint_r : dn[MW-1:0];
      end
    end else begin
      ramp_target_nxt = setpoint_r;
    end
    err    = EW'(ramp_target_r) - EW'(pv0_r);
    deriv  = (EW+1)'(err) - (EW+1)'(previous_error_r);
    accel  = EW'(ramp_target_nxt) - EW'(ramp_target_r);
    fri    = (pv0_r == '0) && (ramp_target_nxt != '0);
    es_sum = (IW+1)'(error_sum_r) + (IW+1)'(err);
    if (es_sum[IW] != es_sum[IW-1]) begin
      error_sum_nxt = es_sum[IW] ? ES_MIN : ES_MAX;
    end else begin
      error_sum_nxt = es_sum[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_target_r    <= '0;
      error_sum_r      <= '0;
      previous_error_r <= '0;
    end else if (ld[1]) begin
      ramp_target_r    <= ramp_target_nxt;
      error_sum_r      <= error_sum_nxt;
      previous_error_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      deriv1_r <= deriv;
      accel1_r <= accel;
      tgt1_r   <= ramp_target_r;
      fri1_r   <= fri;
    end
  end

  // stage 2: gain and feedforward products
  logic signed [39:0]     p2_r, a2_r, v2_r;
  logic signed [40:0]     d2_r;
  logic signed [IHW+15:0] ihi2_r;
  logic signed [IH+16:0]  ilo2_r;
  logic        [16:0]     fb2_r;
  logic signed [MW-1:0]   tgt2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      p2_r   <= $signed({1'b0, prop_gain_r}) * previous_error_r;
      d2_r   <= $signed({1'b0, deriv_gain_r}) * deriv1_r;
      a2_r   <= ff_acc_r * accel1_r;
      v2_r   <= $signed({1'b0, ff_vel_r}) * ramp_target_r;
      ihi2_r <= $signed(error_sum_r[IW-1:IH]) * $signed({1'b0, integ_gain_r});
      ilo2_r <= $signed({1'b0, error_sum_r[IH-1:0]}) * $signed({1'b0, integ_gain_r});
      fb2_r  <= (fri1_r ? 17'(ff_fri_r) : 17'd0) + 17'(ff_bias_r);
      tgt2_r <= tgt1_r;
    end
  end

  // stage 3: integral product combined and saturated
  logic signed [XW-1:0] ifull;
  logic signed [SW-1:0] isat;
  logic signed [SW-1:0] isat3_r;
  logic signed [39:0]   p3_r, a3_r, v3_r;
  logic signed [40:0]   d3_r;
  logic        [16:0]   fb3_r;
  logic signed [MW-1:0] tgt3_r;

  always_comb begin
    ifull = (XW'(ihi2_r) <<< IH) + XW'(ilo2_r);
    priority if (ifull > XW'(pidrfs_pkg::SUM_MAX)) begin
      isat = pidrfs_pkg::SUM_MAX;
    end else if (ifull < XW'(pidrfs_pkg::SUM_MIN)) begin
      isat = pidrfs_pkg::SUM_MIN;
    end else begin
      isat = ifull[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      isat3_r <= isat;
      p3_r    <= p2_r;
      d3_r    <= d2_r;
      a3_r    <= a2_r;
      v3_r    <= v2_r;
      fb3_r   <= fb2_r;
      tgt3_r  <= tgt2_r;
    end
  end

  // stages 4 to 8: saturating accumulation in fixed order
  logic signed [SW-1:0] s4_r, s5_r, s6_r, s7_r, s8_r;
  logic signed [40:0]   d4_r;
  logic signed [39:0]   a4_r, a5_r, v4_r, v5_r, v6_r;
  logic        [16:0]   fb4_r, fb5_r, fb6_r, fb7_r;
  logic signed [MW-1:0] tgt4_r, tgt5_r, tgt6_r, tgt7_r, tgt8_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_r   <= pidrfs_pkg::sat_add64(SW'(p3_r), isat3_r);
      d4_r   <= d3_r;
      a4_r   <= a3_r;
      v4_r   <= v3_r;
      fb4_r  <= fb3_r;
      tgt4_r <= tgt3_r;
    end
    if (ld[5]) begin
      s5_r   <= pidrfs_pkg::sat_add64(s4_r, SW'(d4_r));
      a5_r   <= a4_r;
      v5_r   <= v4_r;
      fb5_r  <= fb4_r;
      tgt5_r <= tgt4_r;
    end
    if (ld[6]) begin
      s6_r   <= pidrfs_pkg::sat_add64(s5_r, SW'(a5_r));
      v6_r   <= v5_r;
      fb6_r  <= fb5_r;
      tgt6_r <= tgt5_r;
    end
    if (ld[7]) begin
      s7_r   <= pidrfs_pkg::sat_add64(s6_r, SW'(v6_r));
      fb7_r  <= fb6_r;
      tgt7_r <= tgt6_r;
    end
    if (ld[8]) begin
      // friction and bias are both non-negative, so one saturating add is exact
      s8_r   <= pidrfs_pkg::sat_add64(s7_r, $signed(SW'(fb7_r) << FRAC_BITS));
      tgt8_r <= tgt7_r;
    end
  end

  // output stage
  pidrfs_pkg::drive_req_t drv_req;
  pidrfs_pkg::drive_lim_t drv_lim;
  logic signed [pidrfs_pkg::DRV_W-1:0] out_drive;
  logic signed [MW-1:0]                out_target;

  assign drv_req = '{sum: s8_r, target: tgt8_r};
  assign drv_lim = '{slew: slew_limit_r, omin: omin_r, omax: omax_r};

  pidrfs_drive #(
    .FRAC_BITS (FRAC_BITS)
  ) u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (v_r[NSTG-1]),
    .req_ready  (drv_ready),
    .req        (drv_req),
    .lim        (drv_lim),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_drive  (out_drive),
    .out_target (out_target)
  );

  assign out_tdata = {1'b0, out_target, out_drive};

endmodule

FILE: rtl/pidrfs_drive.sv
// output stage: floor shift, slew limit, min/max clamp and result register
module pidrfs_drive #(
  parameter int FRAC_BITS = pidrfs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  pidrfs_pkg::drive_req_t                 req,
  input  pidrfs_pkg::drive_lim_t                 lim,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pidrfs_pkg::DRV_W-1:0]    out_drive,
  output logic signed [pidrfs_pkg::MV_W-1:0]     out_target
);

  logic                                   valid_r;
  logic signed [pidrfs_pkg::DRV_W-1:0]    drive_r;
  logic signed [pidrfs_pkg::MV_W-1:0]     target_r;
  logic signed [pidrfs_pkg::DRV_W-1:0]    drive_nxt;

  logic signed [pidrfs_pkg::SUM_W-1:0] drv_sh;
  logic signed [pidrfs_pkg::SUM_W-1:0] prev_ext;
  logic signed [pidrfs_pkg::SUM_W-1:0] slew_ext;
  logic signed [pidrfs_pkg::SUM_W-1:0] dif;
  logic signed [pidrfs_pkg::SUM_W-1:0] slewed;
  logic signed [pidrfs_pkg::SUM_W-1:0] clamped;
  logic signed [pidrfs_pkg::SUM_W-1:0] omin_ext;
  logic signed [pidrfs_pkg::SUM_W-1:0] omax_ext;

  assign req_ready = !valid_r || out_ready;

  always_comb begin
    drv_sh   = $signed(req.sum) >>> FRAC_BITS;
    prev_ext = pidrfs_pkg::SUM_W'(drive_r);
    slew_ext = $signed(pidrfs_pkg::SUM_W'(lim.slew));
    omin_ext = pidrfs_pkg::SUM_W'($signed(lim.omin));
    omax_ext = pidrfs_pkg::SUM_W'($signed(lim.omax));
    dif      = drv_sh - prev_ext;
    slewed   = drv_sh;
    if (lim.slew != '0) begin
      priority if (dif > slew_ext) begin
        slewed = prev_ext + slew_ext;
      end else if (dif < -slew_ext) begin
        slewed = prev_ext - slew_ext;
      end else begin
        slewed = drv_sh;
      end
    end
    priority if (slewed < omin_ext) begin
      clamped = omin_ext;
    end else if (slewed > omax_ext) begin
      clamped = omax_ext;
    end else begin
      clamped = slewed;
    end
    drive_nxt = clamped[pidrfs_pkg::DRV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      drive_r <= '0;
    end else begin
      if (req_ready) begin
        valid_r <= req_valid;
      end
      if (req_ready && req_valid) begin
        drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      target_r <= req.target;
    end
  end

  assign out_valid  = valid_r;
  assign out_drive  = drive_r;
  assign out_target = target_r;

endmodule

FILE: rtl/pidrfs_checker.sv
// port level checks for the pid controller, bound to the top level
module pidrfs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [pidrfs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // reset empties the pipe and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // input is only refused when the whole pipe is full behind a stalled result
  a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without output stall");

  // a free output side never holds the input off
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

endmodule

bind pid_with_ramp_feedforward_slew pidrfs_checker u_pidrfs_checker (.*);
